FILE: hw/rtl/plp_pkg.sv
// ----------------------------------------------------------------------------
// plp_pkg
// Shared types and constants for the positional list block: operation and
// status codes, field widths and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package plp_pkg;

  // Default number of cells in the list
  localparam int unsigned DefCapacity = 16;

  // Field widths of one input beat and one result beat
  localparam int unsigned OpW    = 2;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned DataW  = 32;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;

  // Packed tdata widths, rounded up to whole bytes
  localparam int unsigned InFieldsW  = OpW + IdxW + DataW;
  localparam int unsigned InTdataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = StatW + CountW + DataW;
  localparam int unsigned OutTdataW  = ((OutFieldsW + 7) / 8) * 8;

  // Operation codes
  localparam logic [OpW-1:0] OP_APPEND = 2'd0;
  localparam logic [OpW-1:0] OP_INSERT = 2'd1;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd2;
  localparam logic [OpW-1:0] OP_READ   = 2'd3;

  // Status codes
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_RANGE = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;
  localparam logic [StatW-1:0] ST_BAD   = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;  // capture the accepted input beat
    logic exec;       // carry out the held operation, load the result
  } plp_cmd_t;

endpackage

FILE: hw/rtl/plp_ctrl.sv
// ----------------------------------------------------------------------------
// plp_ctrl
// Controller: takes one input beat at a time, fires the execute step once
// the result register is free, and owns the result valid flag.
// ----------------------------------------------------------------------------
module plp_ctrl
  import plp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output plp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;
  logic   exec_go;

  // Handshake decode
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  assign cmd.load_item = accept;
  assign cmd.exec      = exec_go;
  assign out_tvalid    = out_valid_r;

  // Next state and result valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hw/rtl/plp_dpath.sv
// ----------------------------------------------------------------------------
// plp_dpath
// Datapath: held operation, fill count, the row of cells (each one holds,
// shifts from a neighbour or loads the new value) and the result register.
// ----------------------------------------------------------------------------
module plp_dpath
  import plp_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  plp_cmd_t                 cmd,
  input  logic [OpW-1:0]           in_opcode,
  input  logic [IdxW-1:0]          in_index,
  input  logic signed [DataW-1:0]  in_data,
  output logic [StatW-1:0]         res_status,
  output logic [CountW-1:0]        res_count,
  output logic signed [DataW-1:0]  res_read_value
);

  localparam int unsigned FillW = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CmpW  = (FillW > IdxW) ? FillW : IdxW;

  // Held item
  logic [OpW-1:0]          op_r;
  logic [IdxW-1:0]         idx_r;
  logic signed [DataW-1:0] data_r;

  // List state
  logic [FillW-1:0]        fill_r;
  logic [FillW-1:0]        fill_nxt;
  logic signed [DataW-1:0] cells_r [CAPACITY];

  // Result register
  logic [StatW-1:0]        status_r;
  logic [CountW-1:0]       count_r;
  logic signed [DataW-1:0] rd_r;

  // Decode
  logic [CmpW-1:0]         idx_c;
  logic [CmpW-1:0]         fill_c;
  logic [CmpW-1:0]         pos_c;
  logic                    full;
  logic                    is_ins;
  logic                    ins_ok;
  logic                    rem_ok;
  logic [StatW-1:0]        status_nxt;
  logic signed [DataW-1:0] rd_nxt;
  logic [AddrW-1:0]        rd_addr;

  assign idx_c   = CmpW'(idx_r);
  assign fill_c  = CmpW'(fill_r);
  assign full    = (fill_r == FillW'(CAPACITY));
  assign is_ins  = (op_r == OP_APPEND) || (op_r == OP_INSERT);
  // an append is an insert at the fill position
  assign pos_c   = (op_r == OP_APPEND) ? fill_c : idx_c;
  assign rd_addr = AddrW'(idx_r);

  // Status, count and read value of the held operation
  always_comb begin
    status_nxt = ST_OK;
    rd_nxt     = '0;
    ins_ok     = 1'b0;
    rem_ok     = 1'b0;
    case (op_r)
      OP_APPEND, OP_INSERT: begin
        if (pos_c > fill_c) begin
          status_nxt = ST_RANGE;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ins_ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (idx_c >= fill_c) begin
          status_nxt = ST_RANGE;
        end else begin
          rem_ok = 1'b1;
        end
      end
      OP_READ: begin
        if (idx_c >= fill_c) begin
          status_nxt = ST_RANGE;
        end else begin
          rd_nxt = cells_r[rd_addr];
        end
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.exec && ins_ok) begin
      fill_nxt = fill_r + FillW'(1);
    end else if (cmd.exec && rem_ok) begin
      fill_nxt = fill_r - FillW'(1);
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Item and result capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r   <= in_opcode;
      idx_r  <= in_index;
      data_r <= in_data;
    end
    if (cmd.exec) begin
      status_r <= status_nxt;
      count_r  <= CountW'(fill_nxt);
      rd_r     <= rd_nxt;
    end
  end

  // Row of cells: each decides locally to hold, shift or load
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DataW-1:0] up_src;
    logic signed [DataW-1:0] dn_src;
    logic                    at_pos;
    logic                    above_pos;
    logic                    from_idx;

    if (i > 0) begin : g_up
      assign up_src = cells_r[i-1];
    end else begin : g_up0
      assign up_src = cells_r[i];
    end
    if (i < CAPACITY - 1) begin : g_dn
      assign dn_src = cells_r[i+1];
    end else begin : g_dn_last
      assign dn_src = cells_r[i];
    end

    assign at_pos    = (pos_c == CmpW'(i));
    assign above_pos = (CmpW'(i) > pos_c);
    assign from_idx  = (CmpW'(i) >= idx_c);

    always_ff @(posedge clk) begin
      if (cmd.exec && is_ins && ins_ok) begin
        if (at_pos) begin
          cells_r[i] <= data_r;
        end else if (above_pos) begin
          cells_r[i] <= up_src;
        end
      end else if (cmd.exec && rem_ok && from_idx) begin
        cells_r[i] <= dn_src;
      end
    end
  end

  assign res_status     = status_r;
  assign res_count      = count_r;
  assign res_read_value = rd_r;

endmodule

FILE: hw/rtl/positional_list_insert_remove.sv
// ----------------------------------------------------------------------------
// positional_list_insert_remove
// Bounded ordered list of signed 32-bit values with append, insert, remove
// and read by position; one result beat per input beat.
//
//  channel  dir  fields (tdata, lowest bit first)
//  in_      in   opcode[1:0], index[6:2], data[38:7], pad[39]
//  out_     out  status[1:0], count[6:2], read_value[38:7], pad[39]
//
// An item is accepted first; then the cell row runs and the result
// register is loaded. The execute step waits while a previous result is
// still held in the result register. One item is in flight at a
// time. Synchronous active-low reset empties the list; cell contents are
// not cleared. Stalls on out_tready hold the result and, once an item is
// taken, hold in_tready low.
// ----------------------------------------------------------------------------
module positional_list_insert_remove
  import plp_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [InTdataW-1:0]  in_tdata,   // opcode, index, data, zero pad
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OutTdataW-1:0] out_tdata   // status, count, read_value, pad
);

  plp_cmd_t                cmd;
  logic [StatW-1:0]        res_status;
  logic [CountW-1:0]       res_count;
  logic signed [DataW-1:0] res_read_value;

  plp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  plp_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_opcode      (in_tdata[OpW-1:0]),
    .in_index       (in_tdata[OpW+IdxW-1:OpW]),
    .in_data        (in_tdata[InFieldsW-1:OpW+IdxW]),
    .res_status     (res_status),
    .res_count      (res_count),
    .res_read_value (res_read_value)
  );

  // Pack result beat
  assign out_tdata = OutTdataW'({res_read_value, res_count, res_status});

endmodule

FILE: hw/rtl/plp_checker.sv
// ----------------------------------------------------------------------------
// plp_checker
// Port-level checks on the positional list block, bound to the top level.
// ----------------------------------------------------------------------------
module plp_checker
  import plp_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OutTdataW-1:0] out_tdata
);

  // Held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // One item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while an item is in flight");

  // Status is a defined code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[StatW-1:0] != ST_BAD)
    else $error("undefined status code");

  // Failed operations return a zero read value
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[StatW-1:0] != ST_OK
      |-> out_tdata[OutFieldsW-1:StatW+CountW] == '0)
    else $error("non-zero read value on a failed operation");

endmodule

bind positional_list_insert_remove plp_checker u_plp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
